// File: src/uer_pkg.sv
// Package for the ultrasonic echo ranger: field widths, register map,
// reset values and counter limits. No dependencies.
package uer_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TRIG_W      = 10;
	localparam int TICK_W      = 22;
	localparam int SCALE_W     = 16;
	localparam int DIST_W      = 19;
	localparam int FRAC_SHIFT  = 8;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// product wide enough to see every bit above the saturation point
	localparam int PROD_RAW_W  = COUNT_WIDTH + SCALE_W;
	localparam int PROD_W      = (PROD_RAW_W > DIST_W + FRAC_SHIFT + 1) ?
		PROD_RAW_W : DIST_W + FRAC_SHIFT + 1;

	localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};
	localparam logic [TICK_W-1:0]      TICK_MAX    = {TICK_W{1'b1}};
	localparam logic [DIST_W-1:0]      DIST_MAX    = {DIST_W{1'b1}};

	localparam logic [TRIG_W-1:0]  TRIG_RST     = TRIG_W'(20);
	localparam logic [TICK_W-1:0]  INTERVAL_RST = TICK_W'(100000);
	localparam logic [TICK_W-1:0]  TIMEOUT_RST  = TICK_W'(1500000);
	localparam logic [SCALE_W-1:0] SCALE_RST    = SCALE_W'(1114);

	typedef enum logic [1:0] {
		REG_TRIGGER  = 2'd0,
		REG_INTERVAL = 2'd1,
		REG_TIMEOUT  = 2'd2,
		REG_SCALE    = 2'd3
	} reg_idx_t;

endpackage

// File: src/ultrasonic_echo_ranger_core.sv
// Ultrasonic trigger/echo range finder core: input stage, one-tick update
// of trigger, timers and echo counter, registered result. Uses uer_pkg.
//
//  channel   handshake                  payload
//  -------   -------------------------  ------------------------------------
//  cfg       psel/penable/pwrite/pready paddr, pwdata, prdata
//  in        in_valid/in_ready          echo_level, measure_request
//  out       out_valid/out_ready        trigger_level, distance_q8,
//                                       new_result, busy_res
//
// One item per cycle while the output is not stalled; an item passes the
// input register, then the state update and the 16x16 distance multiply
// into the result register.
// Reset clears all timers, the echo state and the registers to their
// defaults. A stalled output holds the input stage; in_ready drops only
// when both stages are full and out_ready is low.
module ultrasonic_echo_ranger_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [uer_pkg::ADDR_W-1:0]           paddr,
	input  logic [uer_pkg::DATA_W-1:0]           pwdata,
	output logic [uer_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 echo_level,
	input  logic                                 measure_request,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 trigger_level,
	output logic [uer_pkg::DIST_W-1:0]           distance_q8,
	output logic                                 new_result,
	output logic                                 busy_res
);

	// config registers
	logic [uer_pkg::TRIG_W-1:0]  trig_ticks_q;
	logic [uer_pkg::TICK_W-1:0]  interval_q;
	logic [uer_pkg::TICK_W-1:0]  timeout_q;
	logic [uer_pkg::SCALE_W-1:0] scale_q;
	logic                        cfg_wr;
	uer_pkg::reg_idx_t           cfg_idx;

	// input stage
	logic valid_s1;
	logic echo_s1;
	logic req_s1;
	logic advance;
	logic step;

	// measurement state
	logic                             echo_prev_q;
	logic                             await_fall_q;
	logic [uer_pkg::COUNT_WIDTH-1:0]  echo_cnt_q;
	logic [uer_pkg::TRIG_W-1:0]       trig_left_q;
	logic                             busy_q;
	logic [uer_pkg::TICK_W-1:0]       since_start_q;
	logic [uer_pkg::TICK_W-1:0]       since_req_q;
	logic [uer_pkg::DIST_W-1:0]       dist_hold_q;

	// result stage
	logic out_valid_q;
	logic trig_out_q;
	logic fresh_q;

	// next-state logic
	logic [uer_pkg::TICK_W-1:0]      ss_inc;
	logic [uer_pkg::TICK_W-1:0]      sr_inc;
	logic [uer_pkg::COUNT_WIDTH-1:0] cnt_inc;
	logic                            counted;
	logic                            start;
	logic                            abort;
	logic [uer_pkg::TRIG_W-1:0]      tl_load;
	logic                            trig;
	logic                            rise;
	logic                            fall;
	logic [uer_pkg::PROD_W-1:0]      product;
	logic                            dist_ovf;
	logic [uer_pkg::DIST_W-1:0]      dist_new;

	assign pready  = 1'b1;
	assign cfg_idx = uer_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			uer_pkg::REG_TRIGGER:  prdata = uer_pkg::DATA_W'(trig_ticks_q);
			uer_pkg::REG_INTERVAL: prdata = uer_pkg::DATA_W'(interval_q);
			uer_pkg::REG_TIMEOUT:  prdata = uer_pkg::DATA_W'(timeout_q);
			uer_pkg::REG_SCALE:    prdata = uer_pkg::DATA_W'(scale_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= uer_pkg::TRIG_RST;
			interval_q   <= uer_pkg::INTERVAL_RST;
			timeout_q    <= uer_pkg::TIMEOUT_RST;
			scale_q      <= uer_pkg::SCALE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				uer_pkg::REG_TRIGGER:  trig_ticks_q <= pwdata[uer_pkg::TRIG_W-1:0];
				uer_pkg::REG_INTERVAL: interval_q   <= pwdata[uer_pkg::TICK_W-1:0];
				uer_pkg::REG_TIMEOUT:  timeout_q    <= pwdata[uer_pkg::TICK_W-1:0];
				uer_pkg::REG_SCALE:    scale_q      <= pwdata[uer_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			echo_s1 <= echo_level;
			req_s1  <= measure_request;
		end
	end

	// one tick of the ranger
	always_comb begin
		ss_inc  = (since_start_q == uer_pkg::TICK_MAX) ? since_start_q :
			since_start_q + uer_pkg::TICK_W'(1);
		sr_inc  = (since_req_q == uer_pkg::TICK_MAX) ? since_req_q :
			since_req_q + uer_pkg::TICK_W'(1);
		cnt_inc = (echo_cnt_q >= uer_pkg::COUNT_LIMIT) ? uer_pkg::COUNT_LIMIT :
			echo_cnt_q + uer_pkg::COUNT_WIDTH'(1);

		counted = req_s1 && (sr_inc > interval_q);
		start   = counted && !busy_q;
		abort   = counted && busy_q && (ss_inc > timeout_q);

		tl_load = start ? trig_ticks_q : trig_left_q;
		trig    = (tl_load != '0);

		rise = echo_s1 && !echo_prev_q && !await_fall_q;
		fall = !echo_s1 && echo_prev_q && await_fall_q;

		product  = uer_pkg::PROD_W'(cnt_inc) * uer_pkg::PROD_W'(scale_q);
		dist_ovf = |product[uer_pkg::PROD_W-1:uer_pkg::DIST_W+uer_pkg::FRAC_SHIFT];
		dist_new = dist_ovf ? uer_pkg::DIST_MAX :
			product[uer_pkg::DIST_W+uer_pkg::FRAC_SHIFT-1:uer_pkg::FRAC_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q   <= 1'b0;
			await_fall_q  <= 1'b0;
			echo_cnt_q    <= '0;
			trig_left_q   <= '0;
			busy_q        <= 1'b0;
			since_start_q <= '0;
			since_req_q   <= '0;
			dist_hold_q   <= '0;
		end else if (step) begin
			echo_prev_q   <= echo_s1;
			since_start_q <= start ? '0 : ss_inc;
			since_req_q   <= counted ? '0 : sr_inc;
			trig_left_q   <= trig ? tl_load - uer_pkg::TRIG_W'(1) : '0;
			if (rise) begin
				echo_cnt_q   <= '0;
				await_fall_q <= 1'b1;
			end else begin
				echo_cnt_q <= cnt_inc;
			end
			// falling edge wins over a start on the same tick
			if (fall) begin
				dist_hold_q  <= dist_new;
				await_fall_q <= 1'b0;
				busy_q       <= 1'b0;
			end else if (abort) begin
				busy_q <= 1'b0;
			end else if (start) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			trig_out_q  <= 1'b0;
			fresh_q     <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				trig_out_q <= trig;
				fresh_q    <= fall;
			end
		end
	end

	// distance and busy are state that only moves when a result is loaded
	assign out_valid     = out_valid_q;
	assign trigger_level = trig_out_q;
	assign new_result    = fresh_q;
	assign distance_q8   = dist_hold_q;
	assign busy_res      = busy_q;

endmodule

// File: src/uer_checker.sv
// Port-level checks for the echo ranger core, bound to the top level.
// Uses uer_pkg for widths.
module uer_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pready,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       trigger_level,
	input logic [uer_pkg::DIST_W-1:0] distance_q8,
	input logic                       new_result,
	input logic                       busy_res
);

	// a fresh distance always ends the measurement
	a_fresh_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_result |-> !busy_res)
		else $error("new_result with busy_res set");

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output");

	// distance moves only together with a fresh result
	a_dist_only_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !new_result && $past(out_valid) && $past(out_ready)
		|-> $stable(distance_q8))
		else $error("distance changed without new_result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_q8)
		&& $stable(trigger_level) && $stable(new_result) && $stable(busy_res))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (.*);

// File: dv/tb_ultrasonic_echo_ranger_core.sv
// Testbench for ultrasonic_echo_ranger_core: drives echo/request ticks, writes the
// registers over APB between phases and checks every result against a tick predictor.
// Depends on uer_pkg and the core RTL only.
module tb_ultrasonic_echo_ranger_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic echo;
		logic req;
	} tick_in_t;

	typedef struct packed {
		logic                       trig;
		logic [uer_pkg::DIST_W-1:0] distance;
		logic                       fresh;
		logic                       busy;
	} ranging_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [uer_pkg::ADDR_W-1:0]   paddr = '0;
	logic [uer_pkg::DATA_W-1:0]   pwdata = '0;
	logic [uer_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         echo_level = 1'b0;
	logic                         measure_request = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         trigger_level;
	logic [uer_pkg::DIST_W-1:0]   distance_q8;
	logic                         new_result;
	logic                         busy_res;

	ultrasonic_echo_ranger_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.echo_level(echo_level),
		.measure_request(measure_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger_level(trigger_level),
		.distance_q8(distance_q8),
		.new_result(new_result),
		.busy_res(busy_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ranger registers as seen by the predictor
	logic [uer_pkg::TRIG_W-1:0]      trig_len_cfg;
	logic [uer_pkg::TICK_W-1:0]      interval_cfg;
	logic [uer_pkg::TICK_W-1:0]      timeout_cfg;
	logic [uer_pkg::SCALE_W-1:0]     scale_cfg;

	// ranger state as seen by the predictor
	logic                            echo_was;
	logic                            armed_fall;
	logic [uer_pkg::COUNT_WIDTH-1:0] echo_ticks;
	logic [uer_pkg::TRIG_W-1:0]      trig_remaining;
	logic                            busy_now;
	logic [uer_pkg::TICK_W-1:0]      ticks_since_start;
	logic [uer_pkg::TICK_W-1:0]      ticks_since_req;
	logic [uer_pkg::DIST_W-1:0]      dist_held;

	tick_in_t tick_queue[$];
	ranging_t ranging_due[$];
	int       mismatch_count = 0;
	int       result_no = 0;
	bit       calm = 1'b0;

	function automatic ranging_t advance_ranger(input logic echo, input logic req);
		ranging_t     r;
		logic [31:0]  prod;
		if (ticks_since_start != uer_pkg::TICK_MAX)
			ticks_since_start = ticks_since_start + 1'b1;
		if (ticks_since_req != uer_pkg::TICK_MAX)
			ticks_since_req = ticks_since_req + 1'b1;
		if (echo_ticks < uer_pkg::COUNT_LIMIT) echo_ticks = echo_ticks + 1'b1;

		if (req && ticks_since_req > interval_cfg) begin
			if (!busy_now) begin
				trig_remaining = trig_len_cfg;
				ticks_since_start = '0;
				busy_now = 1'b1;
			end else if (ticks_since_start > timeout_cfg) begin
				busy_now = 1'b0;
			end
			ticks_since_req = '0;
		end

		r.trig = (trig_remaining != '0);
		if (trig_remaining != '0) trig_remaining = trig_remaining - 1'b1;

		r.fresh = 1'b0;
		if (echo && !echo_was && !armed_fall) begin
			echo_ticks = '0;
			armed_fall = 1'b1;
		end else if (!echo && echo_was && armed_fall) begin
			prod = 32'(echo_ticks) * 32'(scale_cfg);
			prod = prod >> uer_pkg::FRAC_SHIFT;
			dist_held = (prod > 32'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX :
				prod[uer_pkg::DIST_W-1:0];
			armed_fall = 1'b0;
			busy_now = 1'b0;
			r.fresh = 1'b1;
		end
		echo_was = echo;

		r.distance = dist_held;
		r.busy = busy_now;
		return r;
	endfunction

	function automatic int pick_delay();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s got 0x%0h want 0x%0h", result_no, what, got, want);
		mismatch_count++;
	endtask

	// driver: one item per handshake, random gaps between items
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		tick_in_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			echo_level <= 1'b0;
			measure_request <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				ranging_due.push_back(advance_ranger(echo_level, measure_request));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (tick_queue.size() > 0) begin
					nxt = tick_queue.pop_front();
					in_valid <= 1'b1;
					echo_level <= nxt.echo;
					measure_request <= nxt.req;
					gap_left <= pick_delay();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, field-by-field compare against the oldest expectation
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		ranging_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (ranging_due.size() == 0) begin
					report_mismatch("unexpected item, trigger_level", trigger_level, 0);
				end else begin
					want = ranging_due.pop_front();
					if (trigger_level !== want.trig)
						report_mismatch("trigger_level", trigger_level, want.trig);
					if (distance_q8 !== want.distance)
						report_mismatch("distance_q8", distance_q8, want.distance);
					if (new_result !== want.fresh)
						report_mismatch("new_result", new_result, want.fresh);
					if (busy_res !== want.busy)
						report_mismatch("busy_res", busy_res, want.busy);
				end
				result_no++;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= pick_delay();
			end
		end
	end

	task automatic reset_ranger_model();
		trig_len_cfg = uer_pkg::TRIG_RST;
		interval_cfg = uer_pkg::INTERVAL_RST;
		timeout_cfg = uer_pkg::TIMEOUT_RST;
		scale_cfg = uer_pkg::SCALE_RST;
		echo_was = 1'b0;
		armed_fall = 1'b0;
		echo_ticks = '0;
		trig_remaining = '0;
		busy_now = 1'b0;
		ticks_since_start = '0;
		ticks_since_req = '0;
		dist_held = '0;
	endtask

	task automatic wait_drained();
		while (tick_queue.size() != 0 || in_valid || ranging_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input uer_pkg::reg_idx_t idx,
			input logic [uer_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			uer_pkg::REG_TRIGGER:  trig_len_cfg = val[uer_pkg::TRIG_W-1:0];
			uer_pkg::REG_INTERVAL: interval_cfg = val[uer_pkg::TICK_W-1:0];
			uer_pkg::REG_TIMEOUT:  timeout_cfg = val[uer_pkg::TICK_W-1:0];
			uer_pkg::REG_SCALE:    scale_cfg = val[uer_pkg::SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_ranger(input logic [31:0] trig, input logic [31:0] interval,
			input logic [31:0] timeout, input logic [31:0] scale);
		wait_drained();
		write_reg(uer_pkg::REG_TRIGGER, trig);
		write_reg(uer_pkg::REG_INTERVAL, interval);
		write_reg(uer_pkg::REG_TIMEOUT, timeout);
		write_reg(uer_pkg::REG_SCALE, scale);
		@(negedge clk);
	endtask

	task automatic push_tick(input logic echo, input logic req);
		tick_in_t t;
		t.echo = echo;
		t.req = req;
		tick_queue.push_back(t);
	endtask

	task automatic push_repeat(input logic echo, input logic req, input int n);
		repeat (n) push_tick(echo, req);
	endtask

	// one request, a short wait, an echo pulse, then a quiet tail; stray requests on top
	task automatic push_measurement();
		int lead;
		int width;
		int tail;
		lead = $urandom_range(0, 8);
		width = $urandom_range(1, 40);
		tail = $urandom_range(1, 10);
		push_tick(1'b0, 1'b1);
		repeat (lead) push_tick(1'b0, $urandom_range(0, 9) == 0);
		repeat (width) push_tick(1'b1, $urandom_range(0, 9) == 0);
		repeat (tail) push_tick(1'b0, $urandom_range(0, 6) == 0);
	endtask

	task automatic push_random_phase(input int n);
		while (tick_queue.size() < n) begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 6))
					push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else
				push_measurement();
		end
	endtask

	initial begin
		reset_ranger_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset register values: long interval, so no request counts yet
		push_random_phase(60);

		// start, trigger pulse, echo count, timeout abort, start on an edge tick
		set_ranger(3, 0, 0, 32'hFFFF);
		push_tick(1'b0, 1'b1);
		push_repeat(1'b0, 1'b0, 2);
		push_repeat(1'b1, 1'b0, 2);
		push_tick(1'b1, 1'b1);
		push_tick(1'b0, 1'b0);
		push_tick(1'b1, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b0);

		// zero-length trigger, zero scale, request spacing of more than two ticks
		set_ranger(0, 2, 32'hFFFF_FFFF, 0);
		push_tick(1'b0, 1'b1);
		push_repeat(1'b1, 1'b0, 2);
		push_tick(1'b0, 1'b0);
		push_repeat(1'b0, 1'b1, 6);

		set_ranger(5, 10, 30, 1114);
		push_random_phase(200);

		// all-ones writes: masked to full-scale values, requests never count
		set_ranger(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
		push_random_phase(150);

		set_ranger(0, 0, 32'h003F_FFFF, 0);
		push_random_phase(200);

		set_ranger(2, 3, 8, 40000);
		calm = 1'b1;
		push_random_phase(200);

		repeat (2) begin
			set_ranger($urandom_range(1, 40), $urandom_range(0, 60), $urandom_range(0, 100),
				$urandom_range(0, 65535));
			calm = 1'b0;
			push_random_phase(250);
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("[ultrasonic_echo_ranger_core] OK");
		else
			$display("[ultrasonic_echo_ranger_core] ERROR");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("[ultrasonic_echo_ranger_core] ERROR");
		$finish;
	end

endmodule
